@@ hdl/assert_macros.svh @@
// assertion macros used by local_endpoint_table_match
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, checked only while out of reset
`define LETM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define LETM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/letm_pkg.sv @@
// shared types and constants of the local endpoint table match block
`default_nettype none

package letm_pkg;

  // default number of table slots
  localparam int TABLE_DEPTH_DEF = 16;

  // request kinds carried in the func field
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // ipv4-mapped marker in bytes 10 and 11
  localparam logic [15:0] MAPPED_TAG = 16'hffff;
  // first byte of the ipv4 loopback net
  localparam logic [7:0] V4_LOOP_NET = 8'd127;

  // one stored table slot
  typedef struct packed {
    logic        v4;
    logic [63:0] hi;
    logic [63:0] lo;
  } letm_entry_t;

endpackage

`default_nettype wire

@@ hdl/letm_store.sv @@
// address table memory: one write port, one registered read port
`default_nettype none

module letm_store
  import letm_pkg::*;
#(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire letm_entry_t      wr_entry,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output letm_entry_t           rd_entry
);

  letm_entry_t mem [DEPTH];
  letm_entry_t rd_entry_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= mem[rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

`default_nettype wire

@@ hdl/local_endpoint_table_match.sv @@
// Writes, loopback queries and empty searches pass from ST_IDLE through ST_DONE into the output
// register. Other queries first read one slot per cycle over the single read port, up to
// n = min(local_count, TABLE_DEPTH) slots, stopping early on a hit. The next request is taken
// back in ST_IDLE. One request in work; a held result stalls it.
// Reset (synchronous, rst_n low) clears local_count and all control state; table contents
// stay undefined until written, no clearing pass.
`default_nettype none

module local_endpoint_table_match
  import letm_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // request channel
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // entry_index[3:0], addr_high[67:4], addr_low[131:68], zero pad
  input  wire logic [135:0] in_tdata,
  // func[0], entry_is_v4[1]
  input  wire logic [1:0]   in_tuser,
  // result channel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // is_local[0], was_loopback[1], was_mapped_v4[2], zero pad
  output logic [7:0]        out_tdata,
  // local_count register
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [4:0]   cfg_data
);

  `include "assert_macros.svh"

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [4:0]         local_count_r;
  logic [CNT_W-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0]   limit_r, limit_nxt;
  logic               rd_vld_r;
  logic [63:0]        q_hi_r, q_lo_r;
  logic               mapped_r, loop_r, hit_r;
  logic               mapped_nxt, loop_nxt, hit_nxt;
  logic               out_tvalid_r;
  logic [2:0]         out_flags_r;

  // request fields
  logic               func;
  logic [3:0]         entry_index;
  logic [63:0]        addr_high, addr_low;
  logic               entry_is_v4;
  logic               in_accept;

  // table ports
  logic               wr_en, rd_en, slot_ok, match, finish;
  logic [IDX_W-1:0]   wr_addr, rd_addr;
  letm_entry_t        wr_entry, rd_entry;
  logic [CMP_W-1:0]   count_ext;

  assign func        = in_tuser[0];
  assign entry_is_v4 = in_tuser[1];
  assign entry_index = in_tdata[3:0];
  assign addr_high   = in_tdata[67:4];
  assign addr_low    = in_tdata[131:68];

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_count_r <= 5'd0;
    end else if (cfg_valid && cfg_ready) begin
      local_count_r <= cfg_data;
    end
  end

  // table write, slots beyond the table are dropped
  assign slot_ok = CMP_W'(entry_index) < CMP_W'(TABLE_DEPTH);
  assign wr_en   = in_accept && (func == FUNC_WRITE) && slot_ok;
  assign wr_addr = IDX_W'(entry_index);
  always_comb begin
    wr_entry.v4 = entry_is_v4;
    wr_entry.hi = entry_is_v4 ? 64'd0 : addr_high;
    wr_entry.lo = entry_is_v4 ? {32'd0, addr_low[31:0]} : addr_low;
  end

  // query decode at acceptance
  always_comb begin
    mapped_nxt = (addr_high == 64'd0) && (addr_low[63:32] == {16'd0, MAPPED_TAG});
    if (mapped_nxt) begin
      loop_nxt = (addr_low[31:24] == V4_LOOP_NET);
    end else begin
      loop_nxt = (addr_high == 64'd0) && (addr_low == 64'd1);
    end
    count_ext = CMP_W'(local_count_r);
    if (count_ext > CMP_W'(TABLE_DEPTH)) begin
      limit_nxt = CNT_W'(TABLE_DEPTH);
    end else begin
      limit_nxt = CNT_W'(local_count_r);
    end
  end

  // compare of the slot read in the previous cycle
  always_comb begin
    if (mapped_r) begin
      match = rd_vld_r && rd_entry.v4 && (rd_entry.lo[31:0] == q_lo_r[31:0]);
    end else begin
      match = rd_vld_r && !rd_entry.v4 && (rd_entry.hi == q_hi_r)
              && (rd_entry.lo == q_lo_r);
    end
  end

  // scan read issue
  assign rd_en   = (state_r == ST_SCAN) && (rd_cnt_r < limit_r) && !match;
  assign rd_addr = rd_cnt_r[IDX_W-1:0];
  assign finish  = match || (rd_cnt_r == limit_r);

  letm_store #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    rd_cnt_nxt = rd_cnt_r;
    hit_nxt    = hit_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          rd_cnt_nxt = '0;
          hit_nxt    = 1'b0;
          if ((func == FUNC_QUERY) && !loop_nxt && (limit_nxt != '0)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
        if (finish) begin
          hit_nxt   = match;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
    end
  end

  // query context
  always_ff @(posedge clk) begin
    rd_cnt_r <= rd_cnt_nxt;
    hit_r    <= hit_nxt;
    if (in_accept) begin
      q_hi_r   <= addr_high;
      q_lo_r   <= addr_low;
      limit_r  <= limit_nxt;
      mapped_r <= (func == FUNC_QUERY) && mapped_nxt;
      loop_r   <= (func == FUNC_QUERY) && loop_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && (!out_tvalid_r || out_tready)) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && (!out_tvalid_r || out_tready)) begin
      out_flags_r <= {mapped_r, loop_r, loop_r || hit_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, out_flags_r};

  // checks
  `LETM_ASSERT(a_write_zero_result, clk, rst_n, (in_accept && (func == FUNC_WRITE)) |=> (state_r == ST_DONE) && !loop_r && !mapped_r && !hit_r, "write request must give an all-zero result")
  `LETM_ASSERT(a_loop_skips_table, clk, rst_n, (state_r == ST_DONE) && loop_r |-> !hit_r, "loopback query must not consult the table")
  `LETM_ASSERT(a_miss_reads_all, clk, rst_n, (state_r == ST_SCAN) && (state_nxt == ST_DONE) && !match |-> (rd_cnt_r == limit_r) && rd_vld_r, "search ended before all slots were compared")
  `LETM_ASSERT(a_scan_in_bounds, clk, rst_n, rd_en |-> (limit_r <= CNT_W'(TABLE_DEPTH)), "scan limit exceeds table depth")
  `LETM_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (state_r == ST_IDLE) && !out_tvalid_r, "reset must leave the block idle")

endmodule

`default_nettype wire

@@ tb/sv/tb_local_endpoint_table_match.sv @@
// self-checking testbench of the local endpoint table match block
`default_nettype none

module tb_local_endpoint_table_match;
  import letm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one request as it travels on the input channel
  typedef struct packed {
    logic        func;
    logic [3:0]  slot;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        v4;
  } request_t;

  // one result, laid out as the low bits of out_tdata
  typedef struct packed {
    logic was_mapped_v4;
    logic was_loopback;
    logic is_local;
  } verdict_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [4:0]   cfg_data = '0;

  // requests waiting to be driven, and results waiting to arrive
  request_t requests_pending[$];
  verdict_t verdicts_due[$];

  // predicted block state
  logic [63:0] tbl_hi[TABLE_DEPTH_DEF];
  logic [63:0] tbl_lo[TABLE_DEPTH_DEF];
  logic        tbl_v4[TABLE_DEPTH_DEF];
  logic [4:0]  search_count = '0;

  // table contents as planned by the stimulus, used to aim queries at real entries
  logic [63:0] plan_hi[TABLE_DEPTH_DEF];
  logic [63:0] plan_lo[TABLE_DEPTH_DEF];
  logic        plan_v4[TABLE_DEPTH_DEF];

  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_cfg_writes = 0;
  int unsigned n_errors = 0;
  logic        in_taken = 1'b0;
  logic        steady = 1'b0;

  local_endpoint_table_match u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // computes the result of one request and applies its effect on the table
  function automatic verdict_t resolve_request(request_t r);
    verdict_t    v;
    logic        mapped;
    logic [31:0] q4;
    int          n;
    v = '0;
    if (r.func == FUNC_WRITE) begin
      tbl_v4[r.slot] = r.v4;
      tbl_hi[r.slot] = r.v4 ? 64'd0 : r.hi;
      tbl_lo[r.slot] = r.v4 ? {32'd0, r.lo[31:0]} : r.lo;
      return v;
    end
    mapped = (r.hi == 64'd0) && (r.lo[63:48] == 16'd0) && (r.lo[47:32] == MAPPED_TAG);
    q4 = r.lo[31:0];
    v.was_mapped_v4 = mapped;
    v.was_loopback = mapped ? (q4[31:24] == V4_LOOP_NET) : (r.hi == 64'd0 && r.lo == 64'd1);
    v.is_local = v.was_loopback;
    n = (search_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(search_count);
    if (!v.was_loopback) begin
      for (int i = 0; i < n; i++) begin
        if (mapped ? (tbl_v4[i] && tbl_lo[i][31:0] == q4)
                   : (!tbl_v4[i] && tbl_hi[i] == r.hi && tbl_lo[i] == r.lo))
          v.is_local = 1'b1;
      end
    end
    return v;
  endfunction

  function automatic string field_label(int b);
    case (b)
      0: return "is_local";
      1: return "was_loopback";
      default: return "was_mapped_v4";
    endcase
  endfunction

  // request driver and result ready, changes inputs on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (requests_pending.size() > 0 && (steady || $urandom_range(99) >= 17)) begin
        request_t r;
        r = requests_pending.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {4'd0, r.lo, r.hi, r.slot};
        in_tuser <= {r.v4, r.func};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= steady || $urandom_range(99) >= 17;
  end

  // monitor: predicts on accepted requests, checks accepted results
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        search_count = cfg_data;
        n_cfg_writes++;
      end
      if (in_tvalid && in_tready) begin
        request_t r;
        r.func = in_tuser[0];
        r.v4   = in_tuser[1];
        r.slot = in_tdata[3:0];
        r.hi   = in_tdata[67:4];
        r.lo   = in_tdata[131:68];
        verdicts_due.push_back(resolve_request(r));
        n_accepted++;
      end
      if (out_tvalid && out_tready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %b", $time, out_tdata[2:0]);
          n_errors++;
        end else begin
          verdict_t want;
          want = verdicts_due.pop_front();
          for (int b = 0; b < 3; b++) begin
            if (out_tdata[b] !== want[b]) begin
              $display("%0t: %s expected %0d got %b", $time, field_label(b), want[b],
                       out_tdata[b]);
              n_errors++;
            end
          end
        end
      end
    end
  end

  task automatic add_write(logic [3:0] slot, logic v4, logic [63:0] hi, logic [63:0] lo);
    request_t r;
    r = '{func: FUNC_WRITE, slot: slot, hi: hi, lo: lo, v4: v4};
    plan_v4[slot] = v4;
    plan_hi[slot] = v4 ? 64'd0 : hi;
    plan_lo[slot] = v4 ? {32'd0, lo[31:0]} : lo;
    requests_pending.push_back(r);
    n_queued++;
  endtask

  // queries carry random slot and family bits, which the block must ignore
  task automatic add_query(logic [63:0] hi, logic [63:0] lo);
    request_t r;
    r = '{func: FUNC_QUERY, slot: 4'($urandom_range(15)), hi: hi, lo: lo,
          v4: 1'($urandom_range(1))};
    requests_pending.push_back(r);
    n_queued++;
  endtask

  // query addressed at whatever the given slot holds
  task automatic add_slot_query(int s, logic flip);
    logic [127:0] a;
    if (plan_v4[s])
      a = {64'd0, 16'd0, MAPPED_TAG, plan_lo[s][31:0]};
    else
      a = {plan_hi[s], plan_lo[s]};
    if (flip)
      a = a ^ (128'd1 << $urandom_range(127));
    add_query(a[127:64], a[63:0]);
  endtask

  task automatic wait_idle();
    while (!(n_accepted == n_queued && verdicts_due.size() == 0))
      @(negedge clk);
  endtask

  task automatic write_count(logic [4:0] value);
    int unsigned seen;
    wait_idle();
    seen = n_cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(negedge clk); while (n_cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_random(int count);
    int unsigned pick;
    int          s;
    logic [63:0] hi;
    logic [63:0] lo;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      s = $urandom_range(TABLE_DEPTH_DEF - 1);
      hi = rand64();
      lo = rand64();
      if (pick < 25)
        add_write(4'(s), 1'($urandom_range(1)), hi, lo);
      else if (pick < 55)
        add_slot_query(s, 1'b0);
      else if (pick < 65)
        add_slot_query(s, 1'b1);
      else if (pick < 70)
        add_query(64'd0, 64'd1);
      else if (pick < 76)
        add_query(64'd0, {16'd0, MAPPED_TAG, V4_LOOP_NET, lo[23:0]});
      else if (pick < 83)
        add_query(64'd0, {16'd0, MAPPED_TAG, lo[31:0]});
      else if (pick < 88)
        add_query(64'd0, {hi[15:0] | 16'd1, MAPPED_TAG, lo[31:0]});
      else if (pick < 93)
        add_query(64'd0, lo);
      else
        add_query(hi, lo);
    end
  endtask

  // stimulus and end of run
  initial begin
    int phase_count[10] = '{0, 1, 5, 16, 31, 8, 17, 3, 16, 12};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill every slot while the search count is still zero
    add_write(4'd0, 1'b0, '1, '1);
    add_write(4'd1, 1'b1, '1, '1);
    add_write(4'd2, 1'b0, 64'd0, 64'd0);
    add_write(4'd3, 1'b1, 64'd0, 64'd0);
    add_write(4'd4, 1'b0, 64'd0, {16'd0, MAPPED_TAG, 32'h0a000001});
    add_write(4'd5, 1'b1, 64'h0123456789abcdef, 64'hfedcba98c0a80001);
    for (int s = 6; s < TABLE_DEPTH_DEF; s++)
      add_write(4'(s), 1'(s & 1), rand64(), rand64());
    add_query(64'd0, 64'd1);
    add_query(64'hffffffffffffffff, 64'hffffffffffffffff);
    write_count(5'd16);

    // loopback forms, mapped forms and exact hits
    add_query(64'd0, 64'd1);
    add_query(64'd0, {16'd0, MAPPED_TAG, 32'h7f000001});
    add_query(64'd0, {16'd0, MAPPED_TAG, 32'h7fffffff});
    add_query(64'd0, {16'd0, MAPPED_TAG, 32'h80000000});
    add_query(64'd0, {16'd0, MAPPED_TAG, 32'hffffffff});
    add_query(64'd0, {16'd0, MAPPED_TAG, 32'h00000000});
    add_query(64'd0, {16'd0, MAPPED_TAG, 32'hc0a80001});
    add_query(64'd0, {16'd0, MAPPED_TAG, 32'h0a000001});
    add_query(64'd1, {16'd0, MAPPED_TAG, 32'h7f000001});
    add_query(64'd0, 64'd2);
    add_query(64'd0, 64'd0);
    add_query('1, '1);
    add_slot_query(TABLE_DEPTH_DEF - 1, 1'b0);

    // random phases, each at its own search count
    for (int p = 0; p < 10; p++) begin
      write_count(5'(phase_count[p]));
      steady = (p == 3);
      add_random(150);
    end

    wait_idle();
    steady = 1'b0;
    repeat (30) @(posedge clk);
    if (n_errors == 0 && verdicts_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hard stop for a hung run
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
